>>> src/mvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared types and constants of the matrix-vector transform core.
// ----------------------------------------------------------------------------
package mvt_pkg;

    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;
    localparam int LANES  = 4;
    localparam int IDX_W  = 2;

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_XFORM = 1'b1
    } t_cmd;

    typedef struct packed {
        logic             valid;
        t_cmd             cmd;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_ctrl;

endpackage
`default_nettype wire

>>> src/mvt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvt_cell
// One matrix column: holds its coefficients, multiplies them by its vector
// component and adds the products to the running row sums.
// ----------------------------------------------------------------------------
module mvt_cell import mvt_pkg::*; #(
    parameter int NR        = 4,
    parameter int COL       = 0,
    parameter int FRAC_BITS = 16,
    parameter int SUM_W     = 66
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_ctrl                        i_ctrl,
    input  logic [NR-1:0][DATA_W-1:0]    i_vec,
    input  logic [NR-1:0][SUM_W-1:0]     i_sum,
    output logic                         o_stall,
    output t_ctrl                        o_ctrl,
    output logic [NR-1:0][DATA_W-1:0]    o_vec,
    output logic [NR-1:0][SUM_W-1:0]     o_sum,
    input  logic                         i_stall
);

    localparam logic [DATA_W-1:0] ONE = DATA_W'(64'd1 << FRAC_BITS);

    logic [NR-1:0][DATA_W-1:0] r_coef;
    t_ctrl                     r_a_ctrl;
    t_ctrl                     r_b_ctrl;
    logic [NR-1:0][DATA_W-1:0] r_a_vec;
    logic [NR-1:0][DATA_W-1:0] r_b_vec;
    logic [NR-1:0][SUM_W-1:0]  r_a_sum;
    logic [NR-1:0][SUM_W-1:0]  r_b_sum;
    logic [NR-1:0][PROD_W-1:0] r_prod;
    logic [NR-1:0][PROD_W-1:0] n_prod;

    logic a_ready;
    logic b_ready;
    logic coef_wr;

    assign b_ready = !r_b_ctrl.valid || !i_stall;
    assign a_ready = !r_a_ctrl.valid || b_ready;
    assign coef_wr = i_ctrl.valid && a_ready && (i_ctrl.cmd == CMD_LOAD)
                     && (i_ctrl.col == IDX_W'(COL)) && (int'(i_ctrl.row) < NR);

    always_comb begin
        logic signed [PROD_W-1:0] ca;
        logic signed [PROD_W-1:0] cb;
        for (int r = 0; r < NR; r++) begin
            ca = {{(PROD_W-DATA_W){r_coef[r][DATA_W-1]}}, r_coef[r]};
            cb = {{(PROD_W-DATA_W){i_vec[COL][DATA_W-1]}}, i_vec[COL]};
            n_prod[r] = ca * cb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctrl.valid <= 1'b0;
            r_b_ctrl.valid <= 1'b0;
            for (int r = 0; r < NR; r++) begin
                r_coef[r] <= (r == COL) ? ONE : '0;
            end
        end else begin
            if (a_ready) begin
                r_a_ctrl <= i_ctrl;
            end
            if (b_ready) begin
                r_b_ctrl <= r_a_ctrl;
            end
            for (int r = 0; r < NR; r++) begin
                if (coef_wr && (i_ctrl.row == IDX_W'(r))) begin
                    r_coef[r] <= i_vec[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a_vec <= i_vec;
            r_a_sum <= i_sum;
            r_prod  <= n_prod;
        end
        if (b_ready) begin
            r_b_vec <= r_a_vec;
            for (int r = 0; r < NR; r++) begin
                r_b_sum[r] <= r_a_sum[r]
                              + {{(SUM_W-PROD_W){r_prod[r][PROD_W-1]}}, r_prod[r]};
            end
        end
    end

    assign o_stall = !a_ready;
    assign o_ctrl  = r_b_ctrl;
    assign o_vec   = r_b_vec;
    assign o_sum   = r_b_sum;

endmodule
`default_nettype wire

>>> src/mvt_sat.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvt_sat
// Output stage: scales the row sums down by the fraction bits, saturates
// them to 32 bits and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module mvt_sat import mvt_pkg::*; #(
    parameter int NR        = 4,
    parameter int FRAC_BITS = 16,
    parameter int SUM_W     = 66
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_ctrl                        i_ctrl,
    input  logic [NR-1:0][SUM_W-1:0]     i_sum,
    output logic                         o_stall,
    output logic                         o_valid,
    output logic [LANES-1:0][DATA_W-1:0] o_data,
    output logic                         o_saturated,
    input  logic                         i_stall
);

    logic                         r_valid;
    logic [LANES-1:0][DATA_W-1:0] r_data;
    logic                         r_sat;
    logic [LANES-1:0][DATA_W-1:0] n_data;
    logic [LANES-1:0]             n_clip;
    logic                         ready;

    assign ready = !r_valid || !i_stall;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        if (g < NR) begin : g_row
            logic signed [SUM_W-1:0] sh;
            logic [SUM_W-DATA_W:0]   hi;
            assign sh        = $signed(i_sum[g]) >>> FRAC_BITS;
            assign hi        = sh[SUM_W-1:DATA_W-1];
            assign n_clip[g] = !((&hi) || !(|hi));
            assign n_data[g] = n_clip[g] ? (sh[SUM_W-1] ? SAT_MIN : SAT_MAX)
                                         : sh[DATA_W-1:0];
        end else begin : g_none
            assign n_clip[g] = 1'b0;
            assign n_data[g] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_ctrl.valid && (i_ctrl.cmd == CMD_XFORM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready) begin
            r_data <= n_data;
            r_sat  <= |n_clip;
        end
    end

    assign o_stall     = !ready;
    assign o_valid     = r_valid;
    assign o_data      = r_data;
    assign o_saturated = r_sat;

endmodule
`default_nettype wire

>>> src/matrix_vector_transform_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_vector_transform_core
// 4x4 Q16.16 matrix times vector with per-row saturation.
//
// Input channel (i_valid / o_stall) carries one command per transfer: a load
// writes the coefficient at (i_row, i_col) from i_x_in and gives no result;
// a transform sends i_x_in..i_w_in and gives one result on the output
// channel (o_valid / i_stall) with the four row dot products and a flag
// that is set when any row was clipped.
// The data path is a chain of one cell per column, each a multiply stage
// and an add stage, followed by the saturation register.
// One command enters per cycle while o_stall is low; loads ride the chain,
// so every command sees exactly the loads sent before it.
// Reset restores the identity matrix and empties the chain; the block takes
// commands as soon as reset is released.
// A stalled receiver freezes the result and backs the chain up one stage at
// a time; o_stall rises only once every stage holds a command.
// ----------------------------------------------------------------------------
module matrix_vector_transform_core import mvt_pkg::*; #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_cmd,
    input  logic [IDX_W-1:0]         i_row,
    input  logic [IDX_W-1:0]         i_col,
    input  logic signed [DATA_W-1:0] i_x_in,
    input  logic signed [DATA_W-1:0] i_y_in,
    input  logic signed [DATA_W-1:0] i_z_in,
    input  logic signed [DATA_W-1:0] i_w_in,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_x_out,
    output logic signed [DATA_W-1:0] o_y_out,
    output logic signed [DATA_W-1:0] o_z_out,
    output logic signed [DATA_W-1:0] o_w_out,
    output logic                     o_saturated
);

    localparam int NR    = (DIM < LANES) ? DIM : LANES;
    localparam int SUM_W = PROD_W + $clog2(NR);

    t_ctrl                        ctrl_c  [NR+1];
    logic [NR-1:0][DATA_W-1:0]    vec_c   [NR+1];
    logic [NR-1:0][SUM_W-1:0]     sum_c   [NR+1];
    logic                         stall_c [NR+1];
    logic [LANES-1:0][DATA_W-1:0] in_lanes;
    logic [LANES-1:0][DATA_W-1:0] out_data;

    assign in_lanes  = {i_w_in, i_z_in, i_y_in, i_x_in};
    assign ctrl_c[0] = {i_valid, t_cmd'(i_cmd), i_row, i_col};
    assign vec_c[0]  = in_lanes[NR-1:0];
    assign sum_c[0]  = '0;

    for (genvar g = 0; g < NR; g++) begin : g_cell
        mvt_cell #(
            .NR        (NR),
            .COL       (g),
            .FRAC_BITS (FRAC_BITS),
            .SUM_W     (SUM_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl_c[g]),
            .i_vec   (vec_c[g]),
            .i_sum   (sum_c[g]),
            .o_stall (stall_c[g]),
            .o_ctrl  (ctrl_c[g+1]),
            .o_vec   (vec_c[g+1]),
            .o_sum   (sum_c[g+1]),
            .i_stall (stall_c[g+1])
        );
    end

    mvt_sat #(
        .NR        (NR),
        .FRAC_BITS (FRAC_BITS),
        .SUM_W     (SUM_W)
    ) u_sat (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl_c[NR]),
        .i_sum       (sum_c[NR]),
        .o_stall     (stall_c[NR]),
        .o_valid     (o_valid),
        .o_data      (out_data),
        .o_saturated (o_saturated),
        .i_stall     (i_stall)
    );

    assign o_stall = stall_c[0];
    assign o_x_out = out_data[0];
    assign o_y_out = out_data[1];
    assign o_z_out = out_data[2];
    assign o_w_out = out_data[3];

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_no_stall_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output register is empty");

    a_sat_extreme : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_x_out == SAT_MAX || o_x_out == SAT_MIN ||
             o_y_out == SAT_MAX || o_y_out == SAT_MIN ||
             o_z_out == SAT_MAX || o_z_out == SAT_MIN ||
             o_w_out == SAT_MAX || o_w_out == SAT_MIN))
        else $error("saturation flag without a clipped component");

endmodule
`default_nettype wire
